FILE: rtl/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   // edge from a (x1, y1) to b (x2, y2); on is low when the edge is not tested
   typedef struct packed {
      point_type a;
      point_type b;
      logic      on;
   } edge_type;

   typedef struct packed {
      logic start;
      logic last;
   } ctrl_type;

endpackage

FILE: rtl/pip_front.sv
`timescale 1ns / 1ps

module pip_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                advance,
   input  pip_pkg::coord_type  point_x,
   input  pip_pkg::coord_type  point_y,
   input  pip_pkg::coord_type  vertex_x,
   input  pip_pkg::coord_type  vertex_y,
   input  logic                last_vertex,
   output logic                valid,
   output pip_pkg::ctrl_type   ctrl,
   output pip_pkg::point_type  point,
   output pip_pkg::edge_type   edge_a,
   output pip_pkg::edge_type   edge_b
);

   logic               mid_polygon_ff, mid_polygon_in;
   logic               valid_ff, valid_in;
   pip_pkg::point_type held_point_ff, held_point_in;
   pip_pkg::point_type first_vertex_ff, first_vertex_in;
   pip_pkg::point_type prev_vertex_ff;
   pip_pkg::ctrl_type  ctrl_ff, ctrl_in;
   pip_pkg::point_type point_ff;
   pip_pkg::edge_type  edge_a_ff, edge_a_in;
   pip_pkg::edge_type  edge_b_ff, edge_b_in;
   pip_pkg::point_type vertex;
   logic               start;

   always_comb begin
      vertex.x        = vertex_x;
      vertex.y        = vertex_y;
      start           = !mid_polygon_ff;
      held_point_in   = held_point_ff;
      first_vertex_in = first_vertex_ff;
      if (start) begin
         held_point_in.x = point_x;
         held_point_in.y = point_y;
         first_vertex_in = vertex;
      end
      mid_polygon_in = accept ? !last_vertex : mid_polygon_ff;
      valid_in       = accept ? 1'b1 : (advance ? 1'b0 : valid_ff);
      ctrl_in.start  = start;
      ctrl_in.last   = last_vertex;
      edge_a_in.a    = vertex;
      edge_a_in.b    = prev_vertex_ff;
      edge_a_in.on   = !start;
      edge_b_in.a    = first_vertex_in;
      edge_b_in.b    = vertex;
      edge_b_in.on   = last_vertex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_polygon_ff <= 1'b0;
         valid_ff       <= 1'b0;
      end else begin
         mid_polygon_ff <= mid_polygon_in;
         valid_ff       <= valid_in;
      end
      if (accept) begin
         held_point_ff   <= held_point_in;
         first_vertex_ff <= first_vertex_in;
         prev_vertex_ff  <= vertex;
         ctrl_ff         <= ctrl_in;
         point_ff        <= held_point_in;
         edge_a_ff       <= edge_a_in;
         edge_b_ff       <= edge_b_in;
      end
   end

   assign valid  = valid_ff;
   assign ctrl   = ctrl_ff;
   assign point  = point_ff;
   assign edge_a = edge_a_ff;
   assign edge_b = edge_b_ff;

endmodule

FILE: rtl/pip_edge_test.sv
`timescale 1ns / 1ps

module pip_edge_test (
   input  logic               clock,
   input  logic               load_diff,
   input  logic               load_prod,
   input  pip_pkg::point_type point,
   input  pip_pkg::edge_type  edge_in,
   output logic               crosses
);

   pip_pkg::diff_type d0_ff, d0_in;
   pip_pkg::diff_type dy_ff, dy_in;
   pip_pkg::diff_type dx_ff, dx_in;
   pip_pkg::diff_type d1_ff, d1_in;
   logic              straddle2_ff, straddle2_in;
   pip_pkg::prod_type lhs_ff, lhs_in;
   pip_pkg::prod_type rhs_ff, rhs_in;
   logic              straddle3_ff;
   logic              dy_pos_ff, dy_pos_in;

   // px - x1 < (x2 - x1) * (py - y1) / dy, cross-multiplied by dy
   always_comb begin
      d0_in = pip_pkg::diff_type'(point.x) - pip_pkg::diff_type'(edge_in.a.x);
      dy_in = pip_pkg::diff_type'(edge_in.b.y) - pip_pkg::diff_type'(edge_in.a.y);
      dx_in = pip_pkg::diff_type'(edge_in.b.x) - pip_pkg::diff_type'(edge_in.a.x);
      d1_in = pip_pkg::diff_type'(point.y) - pip_pkg::diff_type'(edge_in.a.y);
      straddle2_in = edge_in.on &&
                     ((edge_in.a.y > point.y) != (edge_in.b.y > point.y));
      lhs_in    = pip_pkg::prod_type'(d0_ff) * pip_pkg::prod_type'(dy_ff);
      rhs_in    = pip_pkg::prod_type'(dx_ff) * pip_pkg::prod_type'(d1_ff);
      dy_pos_in = !dy_ff[pip_pkg::DIFF_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (load_diff) begin
         d0_ff        <= d0_in;
         dy_ff        <= dy_in;
         dx_ff        <= dx_in;
         d1_ff        <= d1_in;
         straddle2_ff <= straddle2_in;
      end
      if (load_prod) begin
         lhs_ff       <= lhs_in;
         rhs_ff       <= rhs_in;
         straddle3_ff <= straddle2_ff;
         dy_pos_ff    <= dy_pos_in;
      end
   end

   assign crosses = straddle3_ff && (dy_pos_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff));

endmodule

FILE: rtl/pip_parity.sv
`timescale 1ns / 1ps

module pip_parity (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  pip_pkg::ctrl_type ctrl,
   input  logic              cross_a,
   input  logic              cross_b,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              rsp_inside_res
);

   logic parity_ff, parity_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic inside_ff;

   always_comb begin
      parity_in    = (ctrl.start ? 1'b0 : parity_ff) ^ cross_a ^ (ctrl.last & cross_b);
      rsp_valid_in = rsp_valid_ff;
      if (advance && ctrl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            parity_ff <= parity_in;
         end
      end
      if (advance && ctrl.last) begin
         inside_ff <= parity_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = inside_ff;

endmodule

FILE: rtl/point_in_polygon_core.sv
`timescale 1ns / 1ps

// Crossing-number point-in-polygon test on a stream of vertices, one vertex per clock
// cycle when the result side keeps up. The query point and the first vertex are taken
// from the first transaction of each polygon; the transaction flagged last_vertex closes
// the polygon and produces one result, 1 when the point is inside. The pipeline is four
// registers deep (input, coordinate differences, exact 25x25 products, parity and result);
// a stalled result holds the pipeline only once the next polygon's last vertex reaches the
// parity stage, so the next polygon streams in meanwhile.
module point_in_polygon_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pip_pkg::coord_type req_point_x,
   input  pip_pkg::coord_type req_point_y,
   input  pip_pkg::coord_type req_vertex_x,
   input  pip_pkg::coord_type req_vertex_y,
   input  logic               req_last_vertex,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_inside_res
);

   logic               accept;
   logic               v1, v2_ff, v3_ff;
   logic               go1, go2, go3;
   logic               free1, free2, free3;
   pip_pkg::ctrl_type  ctrl1, ctrl2_ff, ctrl3_ff;
   pip_pkg::point_type point1;
   pip_pkg::edge_type  edge_a1, edge_b1;
   logic               cross_a, cross_b;
   logic               out_valid;

   always_comb begin
      go3       = v3_ff && (!ctrl3_ff.last || !out_valid || rsp_ready);
      free3     = !v3_ff || go3;
      go2       = v2_ff && free3;
      free2     = !v2_ff || go2;
      go1       = v1 && free2;
      free1     = !v1 || go1;
      req_ready = free1;
      accept    = req_valid && free1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= go1 ? 1'b1 : (go2 ? 1'b0 : v2_ff);
         v3_ff <= go2 ? 1'b1 : (go3 ? 1'b0 : v3_ff);
      end
      if (go1) begin
         ctrl2_ff <= ctrl1;
      end
      if (go2) begin
         ctrl3_ff <= ctrl2_ff;
      end
   end

   pip_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (go1),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .vertex_x    (req_vertex_x),
      .vertex_y    (req_vertex_y),
      .last_vertex (req_last_vertex),
      .valid       (v1),
      .ctrl        (ctrl1),
      .point       (point1),
      .edge_a      (edge_a1),
      .edge_b      (edge_b1)
   );

   pip_edge_test u_edge_a (
      .clock     (clock),
      .load_diff (go1),
      .load_prod (go2),
      .point     (point1),
      .edge_in   (edge_a1),
      .crosses   (cross_a)
   );

   pip_edge_test u_edge_b (
      .clock     (clock),
      .load_diff (go1),
      .load_prod (go2),
      .point     (point1),
      .edge_in   (edge_b1),
      .crosses   (cross_b)
   );

   pip_parity u_parity (
      .clock          (clock),
      .reset          (reset),
      .advance        (go3),
      .ctrl           (ctrl3_ff),
      .cross_a        (cross_a),
      .cross_b        (cross_b),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (out_valid),
      .rsp_inside_res (rsp_inside_res)
   );

   assign rsp_valid = out_valid;

endmodule

FILE: rtl/pip_checker.sv
`timescale 1ns / 1ps

module pip_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_vertex,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_inside_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res))
      else $error("result dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled while the result side is free");

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_vertex && !rsp_valid && rsp_ready
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("closing vertex gave no result in four cycles");

endmodule

bind point_in_polygon_core pip_checker u_pip_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_vertex (req_last_vertex),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_inside_res  (rsp_inside_res)
);
